// File: rtl/order_table_hash_admit_and_state_assert.svh
// Assertion macros shared by the order table RTL.
`ifndef ORDER_TABLE_HASH_ADMIT_AND_STATE_ASSERT_SVH
`define ORDER_TABLE_HASH_ADMIT_AND_STATE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OT_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define OT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`endif

// File: rtl/ot_pkg.sv
// Package with codes, types and hash constants of the order table.
package ot_pkg;
	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

	localparam logic [2:0] K_ADMIT = 3'd0;
	localparam logic [2:0] K_ENC_OK = 3'd1;
	localparam logic [2:0] K_ENC_FAIL = 3'd2;
	localparam logic [2:0] K_INIT_FAIL = 3'd3;
	localparam logic [2:0] K_WRITE_INIT = 3'd4;
	localparam logic [2:0] K_UNKNOWN = 3'd5;
	localparam logic [2:0] K_UNK_FAULT = 3'd6;
	localparam logic [2:0] K_LOOKUP = 3'd7;

	localparam logic [2:0] S_ADMITTED = 3'd0;
	localparam logic [2:0] S_DUPLICATE = 3'd1;
	localparam logic [2:0] S_FULL = 3'd2;
	localparam logic [2:0] S_INVALID = 3'd3;
	localparam logic [2:0] S_TRANS_OK = 3'd4;
	localparam logic [2:0] S_FOUND = 3'd5;
	localparam logic [2:0] S_NOT_FOUND = 3'd6;

	localparam logic [2:0] ST_PEND_ENC = 3'd0;
	localparam logic [2:0] ST_PEND_INIT = 3'd1;
	localparam logic [2:0] ST_WRITE_INIT = 3'd2;
	localparam logic [2:0] ST_LOC_FAILED = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	// One hash result handed from the hash unit to the probe engine.
	typedef struct packed {
		logic [63:0] hash;
		logic        valid;
	} ot_hash_t;
endpackage

// File: rtl/order_table_hash_admit_and_state.sv
// Top level of the order table: handshakes, probe sequencer and slot memory.
//
// Items enter on in valid/ready with kind, key and admit check fields; one
// result per item leaves on the out valid/ready channel. The capacity
// register is written over the cfg valid/ready channel while idle.
// An item is handled alone: the key is hashed one byte at a time through an
// xor and a low and a high partial product, the hash is reduced modulo the
// capacity by a bit-serial remainder unit, then the probe walk reads one
// slot at a time from the slot memory, whose read is registered.
// A result waits in the output register while the receiver stalls; the next
// item runs to its result behind it and then holds the input off.
// Reset sets the capacity to 1024 and clears the entry count, then a clearing
// pass zeroes the used bit of every slot before the first transfer is taken;
// a slot's key only counts once its used bit is set.
module order_table_hash_admit_and_state import ot_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [63:0] order_key,
	input  logic [63:0] risk_reservation,
	input  logic [63:0] submit_attempt,
	input  logic [63:0] exposure_quantity,
	input  logic [63:0] econ_quantity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [9:0]  entry_slot,
	output logic [2:0]  order_state,
	output logic        reconcile_required,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	`include "order_table_hash_admit_and_state_assert.svh"

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [63:0] KEY_MASK = (KEY_BYTES == 8) ? '1 :
		((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	typedef enum logic [2:0] {
		P_CLEAR, P_IDLE, P_HASH, P_MOD, P_READ, P_CHECK, P_OUT
	} pstate_t;

	pstate_t     st_q;
	logic [AW-1:0] clr_q;
	logic [10:0] cap_reg_q;
	logic [16:0] cap_q;
	logic [16:0] idx_q;
	logic [16:0] n_q;
	logic [2:0]  kind_q;
	logic [63:0] key_q;
	logic        bad_q;
	logic [16:0] entry_count_q;
	logic [63:0] mem_key [TABLE_DEPTH];
	logic [4:0]  mem_st [TABLE_DEPTH];
	logic [63:0] rd_key_q;
	logic [4:0]  rd_st_q;
	logic        rd_used;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [4:0]  wr_data;
	logic [63:0] wr_key;
	logic        used_set;
	ot_hash_t    hres;
	logic        mod_done;
	logic [10:0] mod_rem;
	logic [16:0] cap_eff;
	logic [2:0]  from_st, to_st;
	logic        set_flag;
	logic        probe_end;
	logic [2:0]  chk_status;
	logic [9:0]  chk_slot;
	logic [2:0]  chk_state;
	logic        chk_rec;
	logic [2:0]  res_status_q;
	logic [9:0]  res_slot_q;
	logic [2:0]  res_state_q;
	logic        res_rec_q;

	// Clamp the capacity register into one to TABLE_DEPTH.
	always_comb begin
		if (cap_reg_q == 11'd0) cap_eff = 17'd1;
		else if ({6'd0, cap_reg_q} > 17'(TABLE_DEPTH)) cap_eff = 17'(TABLE_DEPTH);
		else cap_eff = {6'd0, cap_reg_q};
	end

	ot_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(in_valid && in_ready),
		.key(order_key & KEY_MASK), .res(hres)
	);

	ot_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(hres.valid), .dividend(hres.hash),
		.divisor(cap_q[10:0]), .done(mod_done), .rem(mod_rem)
	);

	// Source and target state of each mark event.
	always_comb begin
		set_flag = 1'b0;
		case (kind_q)
			K_ENC_OK: begin from_st = ST_PEND_ENC; to_st = ST_PEND_INIT; end
			K_ENC_FAIL: begin from_st = ST_PEND_ENC; to_st = ST_LOC_FAILED; end
			K_INIT_FAIL: begin from_st = ST_PEND_INIT; to_st = ST_LOC_FAILED; end
			K_WRITE_INIT: begin from_st = ST_PEND_INIT; to_st = ST_WRITE_INIT; end
			K_UNKNOWN: begin
				from_st = ST_PEND_INIT; to_st = ST_UNKNOWN; set_flag = 1'b1;
			end
			default: begin
				from_st = ST_WRITE_INIT; to_st = ST_UNKNOWN; set_flag = 1'b1;
			end
		endcase
	end

	// Slot memory: key and {used, flag, state}, read registered, written in place.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_st[wr_addr] <= wr_data;
			if (used_set) mem_key[wr_addr] <= wr_key;
		end
		rd_key_q <= mem_key[idx_q[AW-1:0]];
		rd_st_q <= mem_st[idx_q[AW-1:0]];
	end

	assign rd_used = rd_st_q[4];

	// Write-back decision: clearing pass after reset, then the slot under test.
	always_comb begin
		wr_en = 1'b0;
		used_set = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_st_q;
		wr_key = key_q;
		if (st_q == P_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (st_q == P_CHECK) begin
			if (!rd_used && kind_q == K_ADMIT && !bad_q) begin
				wr_en = 1'b1;
				used_set = 1'b1;
				wr_data = {1'b1, 1'b0, ST_PEND_ENC};
			end else if (rd_used && rd_key_q == key_q && kind_q != K_ADMIT &&
					kind_q != K_LOOKUP && rd_st_q[2:0] == from_st) begin
				wr_en = 1'b1;
				wr_data = {1'b1, rd_st_q[3] | set_flag, to_st};
			end
		end
	end

	// The probe ends at an unused slot, the key, or after a full lap.
	assign probe_end = !rd_used || (rd_key_q == key_q) || (n_q + 17'd1 == cap_q);

	// Result of the slot under test when the probe ends there.
	always_comb begin
		chk_status = S_INVALID;
		chk_slot = idx_q[9:0];
		chk_state = rd_st_q[2:0];
		chk_rec = rd_st_q[3];
		if (!rd_used) begin
			chk_slot = '0;
			chk_state = '0;
			chk_rec = 1'b0;
			if (kind_q == K_LOOKUP) chk_status = S_NOT_FOUND;
			else if (kind_q == K_ADMIT && !bad_q) begin
				chk_status = S_ADMITTED;
				chk_slot = idx_q[9:0];
			end
		end else if (rd_key_q == key_q) begin
			if (kind_q == K_ADMIT) chk_status = S_DUPLICATE;
			else if (kind_q == K_LOOKUP) chk_status = S_FOUND;
			else if (rd_st_q[2:0] == from_st) begin
				chk_status = S_TRANS_OK;
				chk_state = to_st;
				chk_rec = rd_st_q[3] | set_flag;
			end
		end else begin
			chk_slot = '0;
			chk_state = '0;
			chk_rec = 1'b0;
			chk_status = (kind_q == K_ADMIT) ? S_FULL :
				(kind_q == K_LOOKUP) ? S_NOT_FOUND : S_INVALID;
		end
	end

	// Probe sequencer, result staging and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= P_CLEAR;
			clr_q <= '0;
			cap_reg_q <= 11'd1024;
			entry_count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) cap_reg_q <= cfg_data;
			if (st_q == P_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (st_q)
				P_CLEAR: begin
					if (clr_q == AW'(TABLE_DEPTH - 1)) st_q <= P_IDLE;
					else clr_q <= clr_q + 1'b1;
				end
				P_IDLE: begin
					if (in_valid && in_ready) begin
						kind_q <= kind;
						key_q <= order_key & KEY_MASK;
						bad_q <= (risk_reservation != submit_attempt) ||
							(exposure_quantity != econ_quantity);
						cap_q <= cap_eff;
						st_q <= P_HASH;
					end
				end
				P_HASH: if (hres.valid) st_q <= P_MOD;
				P_MOD: begin
					if (mod_done) begin
						idx_q <= {6'd0, mod_rem};
						n_q <= '0;
						st_q <= P_READ;
					end
				end
				P_READ: st_q <= P_CHECK;
				P_CHECK: begin
					if (wr_en && used_set) entry_count_q <= entry_count_q + 17'd1;
					if (probe_end) begin
						st_q <= P_OUT;
						res_status_q <= chk_status;
						res_slot_q <= chk_slot;
						res_state_q <= chk_state;
						res_rec_q <= chk_rec;
					end else begin
						n_q <= n_q + 17'd1;
						idx_q <= (idx_q + 17'd1 == cap_q) ? 17'd0 : idx_q + 17'd1;
						st_q <= P_READ;
					end
				end
				P_OUT: begin
					if (!out_valid || out_ready) begin
						status <= res_status_q;
						entry_slot <= res_slot_q;
						order_state <= res_state_q;
						reconcile_required <= res_rec_q;
						st_q <= P_IDLE;
					end
				end
				default: st_q <= P_IDLE;
			endcase
		end
	end

	assign in_ready = (st_q == P_IDLE);
	assign cfg_ready = (st_q == P_IDLE);

	`OT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, entry_count_q <= 17'(TABLE_DEPTH))
	`OT_ASSERT_IMP(a_probe_in_range, clk, arst_n, st_q == P_CHECK, idx_q < cap_q)
	`OT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(entry_slot) && $stable(order_state))
	`OT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, st_q != P_IDLE, !in_ready && !cfg_ready)
endmodule

// File: rtl/ot_hash.sv
// FNV-1a hash unit: one key byte per step, multiply split over 32-bit partial products.
module ot_hash import ot_pkg::*; #(
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output ot_hash_t    res
);
	localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	typedef enum logic [1:0] {H_IDLE, H_XOR, H_MUL_LO, H_MUL_HI} hstate_t;

	hstate_t     st_q;
	logic [63:0] h_q;
	logic [63:0] x_q;
	logic [63:0] lo_q;
	logic [BW-1:0] byte_q;
	logic [63:0] key_q;
	logic        done_q;
	logic [63:0] p_lo;

	// Prime = 2^40 + 0x1B3: the product mod 2^64 is x*0x1B3 + (x << 40).
	assign p_lo = {32'd0, x_q[31:0]} * 64'h1B3;

	// Byte-serial sequencer: xor, then low and high partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
			done_q <= 1'b0;
			byte_q <= '0;
		end else begin
			done_q <= (st_q == H_MUL_HI) && (32'(byte_q) == KEY_BYTES - 1);
			case (st_q)
				H_IDLE: begin
					if (start) begin
						h_q <= FNV_BASIS;
						key_q <= key;
						byte_q <= '0;
						st_q <= H_XOR;
					end
				end
				H_XOR: begin
					x_q <= h_q ^ {56'd0, key_q[7:0]};
					st_q <= H_MUL_LO;
				end
				H_MUL_LO: begin
					lo_q <= p_lo + {x_q[23:0], 40'd0};
					st_q <= H_MUL_HI;
				end
				H_MUL_HI: begin
					h_q <= lo_q + {x_q[63:32] * 32'h1B3, 32'd0};
					key_q <= {8'd0, key_q[63:8]};
					if (32'(byte_q) == KEY_BYTES - 1) begin
						st_q <= H_IDLE;
					end else begin
						byte_q <= byte_q + 1'b1;
						st_q <= H_XOR;
					end
				end
				default: st_q <= H_IDLE;
			endcase
		end
	end

	assign res.hash = h_q;
	assign res.valid = done_q;
endmodule

// File: rtl/ot_mod.sv
// Restoring remainder unit: 64-bit hash modulo the capacity, one bit a cycle.
module ot_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [10:0] divisor,
	output logic        done,
	output logic [10:0] rem
);
	logic [63:0] d_q;
	logic [11:0] r_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [11:0] trial;

	assign trial = {r_q[10:0], d_q[63]};

	// Shift one dividend bit into the partial remainder and subtract if it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= busy_q && !start && (cnt_q == 7'd63);
			if (start) begin
				busy_q <= 1'b1;
				d_q <= dividend;
				r_q <= '0;
				cnt_q <= '0;
			end else if (busy_q) begin
				d_q <= {d_q[62:0], 1'b0};
				r_q <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rem = r_q[10:0];
endmodule

// File: sim/tb_order_table_hash_admit_and_state.sv
// Self-checking testbench for the order table: admit, state marks, lookup, capacity register.
module tb_order_table_hash_admit_and_state import ot_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 1024;
	localparam int CYCLE_LIMIT = 2000000;

	// One expected result.
	typedef struct packed {
		logic [2:0] status;
		logic [9:0] slot;
		logic [2:0] state;
		logic       rec;
	} table_result_t;

	// One directed stimulus row; chk_fixed selects the typed-in expectation.
	typedef struct {
		logic [2:0]    kind;
		logic [63:0]   key;
		logic          consistent;
		logic          chk_fixed;
		table_result_t fixed;
	} order_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = K_LOOKUP;
	logic [63:0] order_key = '0;
	logic [63:0] risk_reservation = '0;
	logic [63:0] submit_attempt = '0;
	logic [63:0] exposure_quantity = '0;
	logic [63:0] econ_quantity = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [9:0]  entry_slot;
	logic [2:0]  order_state;
	logic        reconcile_required;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	order_table_hash_admit_and_state dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .order_key(order_key),
		.risk_reservation(risk_reservation), .submit_attempt(submit_attempt),
		.exposure_quantity(exposure_quantity), .econ_quantity(econ_quantity),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.entry_slot(entry_slot), .order_state(order_state),
		.reconcile_required(reconcile_required),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Shadow copy of the table.
	logic        sh_used [DEPTH];
	logic [63:0] sh_key [DEPTH];
	logic [2:0]  sh_state [DEPTH];
	logic        sh_rec [DEPTH];
	logic [10:0] sh_capacity;
	logic [63:0] known_keys [$];

	table_result_t pending_results [$];
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	bit quiet_tail = 1'b0;
	bit hold_off = 1'b0;
	int status_hits [8];

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int effective_capacity();
		int c;
		c = sh_capacity;
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// FNV-1a over the eight key bytes, low byte first, reduced by capacity.
	function automatic int home_slot(logic [63:0] key, int cap);
		logic [63:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < 8; i++) begin
			h = h ^ {56'd0, key[8*i +: 8]};
			h = h * FNV_PRIME;
		end
		return int'(h % 64'(cap));
	endfunction

	// Compute the result of one order event and update the shadow table.
	function automatic table_result_t order_event(logic [2:0] k, logic [63:0] key,
			logic consistent);
		table_result_t r;
		int cap, idx, found;
		logic [2:0] src, dst;
		logic sets_flag;
		cap = effective_capacity();
		idx = home_slot(key, cap);
		found = 0;
		r = '0;
		for (int n = 0; n < cap; n++) begin
			if (!sh_used[idx]) break;
			if (sh_key[idx] == key) begin
				found = 1;
				break;
			end
			idx = (idx + 1 == cap) ? 0 : idx + 1;
			if (n == cap - 1) idx = cap;
		end
		sets_flag = 1'b0;
		src = ST_PEND_ENC;
		dst = ST_PEND_INIT;
		case (k)
			K_ADMIT: begin
				if (found) r = '{S_DUPLICATE, idx[9:0], sh_state[idx], sh_rec[idx]};
				else if (idx >= cap) r.status = S_FULL;
				else if (!consistent) r.status = S_INVALID;
				else begin
					sh_used[idx] = 1'b1;
					sh_key[idx] = key;
					sh_state[idx] = ST_PEND_ENC;
					sh_rec[idx] = 1'b0;
					r = '{S_ADMITTED, idx[9:0], ST_PEND_ENC, 1'b0};
				end
				return r;
			end
			K_LOOKUP: begin
				if (found) r = '{S_FOUND, idx[9:0], sh_state[idx], sh_rec[idx]};
				else r.status = S_NOT_FOUND;
				return r;
			end
			K_ENC_OK: begin src = ST_PEND_ENC; dst = ST_PEND_INIT; end
			K_ENC_FAIL: begin src = ST_PEND_ENC; dst = ST_LOC_FAILED; end
			K_INIT_FAIL: begin src = ST_PEND_INIT; dst = ST_LOC_FAILED; end
			K_WRITE_INIT: begin src = ST_PEND_INIT; dst = ST_WRITE_INIT; end
			K_UNKNOWN: begin src = ST_PEND_INIT; dst = ST_UNKNOWN; sets_flag = 1'b1; end
			default: begin src = ST_WRITE_INIT; dst = ST_UNKNOWN; sets_flag = 1'b1; end
		endcase
		if (!found) begin
			r.status = S_INVALID;
		end else if (sh_state[idx] != src) begin
			r = '{S_INVALID, idx[9:0], sh_state[idx], sh_rec[idx]};
		end else begin
			sh_state[idx] = dst;
			if (sets_flag) sh_rec[idx] = 1'b1;
			r = '{S_TRANS_OK, idx[9:0], dst, sh_rec[idx]};
		end
		return r;
	endfunction

	// Offer one event and wait for its transfer.
	task automatic send_event(logic [2:0] k, logic [63:0] key, logic consistent,
			logic chk_fixed, table_result_t fixed);
		table_result_t r;
		logic [63:0] a, b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		kind <= k;
		order_key <= key;
		risk_reservation <= a;
		exposure_quantity <= b;
		if (consistent || k != K_ADMIT) begin
			submit_attempt <= (k == K_ADMIT) ? a : {$urandom, $urandom};
			econ_quantity <= (k == K_ADMIT) ? b : {$urandom, $urandom};
		end else if ($urandom_range(0, 1)) begin
			submit_attempt <= a ^ (64'd1 << $urandom_range(0, 63));
			econ_quantity <= b;
		end else begin
			submit_attempt <= a;
			econ_quantity <= b ^ (64'd1 << $urandom_range(0, 63));
		end
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = order_event(k, key, consistent);
		if (chk_fixed && r != fixed)
			$error("directed row expectation differs from prediction for key %h", key);
		pending_results = {pending_results, (chk_fixed ? fixed : r)};
		if (k == K_ADMIT && r.status == S_ADMITTED) known_keys = {known_keys, key};
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Write the capacity register once the table has gone quiet.
	task automatic set_capacity(logic [10:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sh_capacity = value;
	endtask

	// Receiver: random stalls, one long hold-off, and a compare per transfer.
	always @(posedge clk) begin
		table_result_t want;
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				status_hits[want.status] <= status_hits[want.status] + 1;
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status);
					errors++;
				end
				if (entry_slot !== want.slot) begin
					$error("entry_slot expected %0d actual %0d", want.slot, entry_slot);
					errors++;
				end
				if (order_state !== want.state) begin
					$error("order_state expected %0d actual %0d", want.state, order_state);
					errors++;
				end
				if (reconcile_required !== want.rec) begin
					$error("reconcile_required expected %0d actual %0d", want.rec,
						reconcile_required);
					errors++;
				end
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 8) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Random key: mostly a known key, sometimes a fresh one.
	function automatic logic [63:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(0, 99) < 65)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return {$urandom, $urandom};
	endfunction

	order_row_t rows [$];
	logic [63:0] lifecycle_key;

	initial begin
		for (int i = 0; i < DEPTH; i++) sh_used[i] = 1'b0;
		sh_capacity = 11'd1024;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: empty table, extremes, and marks from right and wrong states.
		rows = '{
			'{K_LOOKUP, 64'd0, 1'b1, 1'b1, '{S_NOT_FOUND, 10'd0, 3'd0, 1'b0}},
			'{K_ENC_OK, 64'd0, 1'b1, 1'b1, '{S_INVALID, 10'd0, 3'd0, 1'b0}},
			'{K_ADMIT, 64'd0, 1'b0, 1'b1, '{S_INVALID, 10'd0, 3'd0, 1'b0}},
			'{K_ADMIT, 64'd0, 1'b1, 1'b0, '0},
			'{K_ADMIT, 64'd0, 1'b1, 1'b0, '0},
			'{K_ADMIT, '1, 1'b1, 1'b0, '0},
			'{K_ENC_FAIL, '1, 1'b1, 1'b0, '0},
			'{K_ENC_OK, '1, 1'b1, 1'b0, '0},
			'{K_ENC_OK, 64'd0, 1'b1, 1'b0, '0},
			'{K_INIT_FAIL, 64'd0, 1'b1, 1'b0, '0},
			'{K_LOOKUP, 64'd0, 1'b1, 1'b0, '0},
			'{K_WRITE_INIT, 64'd0, 1'b1, 1'b0, '0},
			'{K_UNK_FAULT, 64'd0, 1'b1, 1'b0, '0}
		};
		foreach (rows[i])
			send_event(rows[i].kind, rows[i].key, rows[i].consistent, rows[i].chk_fixed,
				rows[i].fixed);
		lifecycle_key = 64'h8000_0000_0000_0001;
		send_event(K_ADMIT, lifecycle_key, 1'b1, 1'b0, '0);
		send_event(K_ENC_OK, lifecycle_key, 1'b1, 1'b0, '0);
		send_event(K_WRITE_INIT, lifecycle_key, 1'b1, 1'b0, '0);
		send_event(K_UNK_FAULT, lifecycle_key, 1'b1, 1'b0, '0);
		send_event(K_UNK_FAULT, lifecycle_key, 1'b1, 1'b0, '0);
		send_event(K_LOOKUP, lifecycle_key, 1'b1, 1'b0, '0);
		lifecycle_key = 64'h0123_4567_89AB_CDEF;
		send_event(K_ADMIT, lifecycle_key, 1'b1, 1'b0, '0);
		send_event(K_ENC_OK, lifecycle_key, 1'b1, 1'b0, '0);
		send_event(K_UNKNOWN, lifecycle_key, 1'b1, 1'b0, '0);
		send_event(K_ADMIT, lifecycle_key, 1'b1, 1'b0, '0);

		// Random phases across capacities; tiny ones fill and report a full table.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_capacity(11'd1);
				1: set_capacity(11'd0);
				2: set_capacity(11'd5);
				3: set_capacity(11'd2047);
				4: set_capacity(11'd16);
				5: set_capacity(11'd1024);
				default: set_capacity(11'(61));
			endcase
			if (ph == 4) hold_off = 1'b1;
			if (ph == 6) quiet_tail = 1'b1;
			for (int n = 0; n < 62; n++) begin
				logic [2:0] k;
				k = ($urandom_range(0, 2) == 0) ? K_ADMIT : 3'($urandom_range(0, 7));
				send_event(k, pick_key(), $urandom_range(0, 9) != 0, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d results over seven capacities incl. 0, 1 and 2047.",
			results_seen);
		$display("Status counts: adm %0d dup %0d full %0d inv %0d ok %0d found %0d miss %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4], status_hits[5], status_hits[6]);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
